// ===== hw/rtl/mshw_pkg.sv =====
// ----------------------------------------------------------------------------
// mshw_pkg
// Types and constants shared by the heartbeat watchdog front end, request
// queue and table engine.
// ----------------------------------------------------------------------------
package mshw_pkg;

  // Request codes as they arrive on in_tuser
  localparam logic [2:0] REQ_REGISTER   = 3'd0;
  localparam logic [2:0] REQ_HEARTBEAT  = 3'd1;
  localparam logic [2:0] REQ_STATUS     = 3'd2;
  localparam logic [2:0] REQ_UNREGISTER = 3'd3;
  localparam logic [2:0] REQ_FREEZE     = 3'd4;
  localparam logic [2:0] REQ_RESUME     = 3'd5;

  // Reply status codes
  localparam logic [1:0] RC_OK    = 2'd0;
  localparam logic [1:0] RC_NOENT = 2'd1;
  localparam logic [1:0] RC_FULL  = 2'd2;

  // Reset value of the default window register
  localparam logic [31:0] DEFAULT_WINDOW_RST = 32'd200;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_HEARTBEAT,
    OP_STATUS,
    OP_UNREGISTER,
    OP_FREEZE,
    OP_RESUME,
    OP_UNKNOWN
  } op_t;

  // Entry state, encoded as reported in the status reply
  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_FROZEN   = 2'd2,
    ST_TIMEDOUT = 2'd3
  } slot_st_t;

  // Table engine sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_SEL,
    BK_EXEC
  } bk_state_t;

  // Classified request held in the queue
  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] window;   // already resolved against the default window
  } req_t;

  // One row of the entry data memory
  typedef struct packed {
    logic [31:0] window;
    logic [31:0] ticks;
    logic [31:0] freezes;
  } row_t;

  // Reply, packed so that the first field lands in the highest bits
  typedef struct packed {
    logic        fired;
    logic [31:0] freezes;
    logic [31:0] ticks;
    logic [1:0]  state;
    logic [1:0]  code;
  } res_t;

endpackage

// ===== hw/rtl/mshw_front.sv =====
// ----------------------------------------------------------------------------
// mshw_front
// Accepts request beats, decodes the request type and resolves the window
// against the default window register, then pushes into the request queue.
// ----------------------------------------------------------------------------
module mshw_front import mshw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // [31:0] slot_key, [63:32] window_ticks
  input  logic [2:0]  in_tuser,     // [2:0] req_type
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output req_t        q_data
);

  logic [31:0] default_window_r;
  logic [31:0] window;
  op_t         op;

  // Default window register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_window_r <= DEFAULT_WINDOW_RST;
    end else if (cfg_valid) begin
      default_window_r <= cfg_data;
    end
  end

  // Decode request type
  always_comb begin
    case (in_tuser)
      REQ_REGISTER:   op = OP_REGISTER;
      REQ_HEARTBEAT:  op = OP_HEARTBEAT;
      REQ_STATUS:     op = OP_STATUS;
      REQ_UNREGISTER: op = OP_UNREGISTER;
      REQ_FREEZE:     op = OP_FREEZE;
      REQ_RESUME:     op = OP_RESUME;
      default:        op = OP_UNKNOWN;
    endcase
  end

  // Zero window selects the default
  assign window = (in_tdata[63:32] == 32'd0) ? default_window_r : in_tdata[63:32];

  assign in_tready     = !q_full;
  assign q_push        = in_tvalid && !q_full;
  assign q_data.op     = op;
  assign q_data.key    = in_tdata[31:0];
  assign q_data.window = window;

endmodule

// ===== hw/rtl/mshw_fifo.sv =====
// ----------------------------------------------------------------------------
// mshw_fifo
// Two-entry request queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module mshw_fifo import mshw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  input  logic pop,
  output req_t pop_data,
  output logic full,
  output logic empty
);

  localparam int DEPTH = 2;

  req_t       mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'(DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mshw_back.sv =====
// ----------------------------------------------------------------------------
// mshw_back
// Table engine: key match across all entries, lowest-index select with a
// registered read of the entry data memory, then read-modify-write and
// reply into the output register.
// ----------------------------------------------------------------------------
module mshw_back import mshw_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  req_t q_data,
  input  logic q_empty,
  output logic q_pop,
  output res_t out_res,
  output logic out_valid,
  input  logic out_ready,
  output logic bk_fire
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  bk_state_t   st_r, st_nxt;
  req_t        req_r;
  logic [SLOTS-1:0] match_r, match_nxt;
  logic [SLOTS-1:0] free_r, free_nxt;
  logic        hit_r;
  logic        any_free_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] hit_idx, free_idx;
  row_t        row_r;
  row_t        mem_r [SLOTS];
  slot_st_t    slot_st_r [SLOTS];
  logic [31:0] key_r [SLOTS];
  logic        out_valid_r;
  res_t        out_res_r;

  // Execute-stage results
  res_t        res_nxt;
  row_t        row_nxt;
  slot_st_t    cur_st;
  slot_st_t    new_st;
  logic        st_wr;
  logic        key_wr;
  logic        row_wr;

  // Sequencer next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (!q_empty) st_nxt = BK_MATCH;
      BK_MATCH: st_nxt = BK_SEL;
      BK_SEL:   st_nxt = BK_EXEC;
      BK_EXEC:  if (!out_valid_r || out_ready) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop   = 1'b0;
    bk_fire = 1'b0;
    case (st_r)
      BK_IDLE: q_pop   = !q_empty;
      BK_EXEC: bk_fire = !out_valid_r || out_ready;
      default: begin
        q_pop   = 1'b0;
        bk_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Latch the request on pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r <= q_data;
    end
  end

  // Per-entry key compare and free flags
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_nxt[i] = (slot_st_r[i] != ST_FREE) && (key_r[i] == req_r.key);
      free_nxt[i]  = (slot_st_r[i] == ST_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_MATCH) begin
      match_r <= match_nxt;
      free_r  <= free_nxt;
    end
  end

  // Lowest-index hit and lowest free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_W'(i);
      if (free_r[i]) free_idx = IDX_W'(i);
    end
  end

  assign idx_nxt = (|match_r) ? hit_idx : free_idx;

  // Select stage: registered memory read
  always_ff @(posedge clk) begin
    if (st_r == BK_SEL) begin
      hit_r      <= |match_r;
      any_free_r <= |free_r;
      idx_r      <= idx_nxt;
      row_r      <= mem_r[idx_nxt];
    end
  end

  // Execute: decide the entry update and the reply
  assign cur_st = slot_st_r[idx_r];

  always_comb begin
    res_nxt = '0;
    row_nxt = row_r;
    new_st  = cur_st;
    st_wr   = 1'b0;
    key_wr  = 1'b0;
    row_wr  = 1'b0;
    case (req_r.op)
      OP_REGISTER: begin
        if (hit_r || any_free_r) begin
          st_wr           = 1'b1;
          key_wr          = 1'b1;
          row_wr          = 1'b1;
          new_st          = ST_ACTIVE;
          row_nxt.window  = req_r.window;
          row_nxt.ticks   = req_r.window;
          row_nxt.freezes = 32'd0;
        end else begin
          res_nxt.code = RC_FULL;
        end
      end
      OP_HEARTBEAT: begin
        if (!hit_r) begin
          res_nxt.code = RC_NOENT;
        end else if (cur_st == ST_ACTIVE) begin
          if (row_r.ticks == 32'd0) begin
            st_wr         = 1'b1;
            new_st        = ST_TIMEDOUT;
            res_nxt.fired = 1'b1;
          end else begin
            row_wr        = 1'b1;
            row_nxt.ticks = row_r.ticks - 32'd1;
          end
        end
      end
      OP_STATUS: begin
        if (!hit_r) begin
          res_nxt.code = RC_NOENT;
        end else begin
          res_nxt.state   = cur_st;
          res_nxt.ticks   = row_r.ticks;
          res_nxt.freezes = row_r.freezes;
        end
      end
      OP_UNREGISTER: begin
        if (!hit_r) begin
          res_nxt.code = RC_NOENT;
        end else begin
          st_wr  = 1'b1;
          new_st = ST_FREE;
        end
      end
      OP_FREEZE: begin
        if (!hit_r) begin
          res_nxt.code = RC_NOENT;
        end else begin
          st_wr           = 1'b1;
          row_wr          = 1'b1;
          new_st          = ST_FROZEN;
          row_nxt.freezes = row_r.freezes + 32'd1;
        end
      end
      OP_RESUME: begin
        if (!hit_r) begin
          res_nxt.code = RC_NOENT;
        end else begin
          st_wr         = 1'b1;
          row_wr        = 1'b1;
          new_st        = ST_ACTIVE;
          row_nxt.ticks = row_r.window;
        end
      end
      default: res_nxt.code = RC_NOENT;
    endcase
  end

  // Entry state flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_st_r[i] <= ST_FREE;
      end
    end else if (bk_fire && st_wr) begin
      slot_st_r[idx_r] <= new_st;
    end
  end

  // Key registers
  always_ff @(posedge clk) begin
    if (bk_fire && key_wr) begin
      key_r[idx_r] <= req_r.key;
    end
  end

  // Entry data memory write
  always_ff @(posedge clk) begin
    if (bk_fire && row_wr) begin
      mem_r[idx_r] <= row_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (bk_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== hw/rtl/multi_slot_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_slot_heartbeat_watchdog
// Keyed table of heartbeat watchdog entries with register, heartbeat,
// status, unregister, freeze and resume requests.
// ----------------------------------------------------------------------------
// Every request beat gets exactly one reply beat. The front end takes a
// beat whenever its two-entry request queue has room, so it keeps accepting
// while a reply waits at the output. The table engine handles one request
// at a time, in order: queue pop, compare of the key against all SLOTS
// entries, lowest-index select with the registered read of the entry data
// memory, and the read-modify-write that loads the reply register. It takes
// no new request before that sequence ends; a reply not taken holds the
// engine in its last step. Entry states all reset to free together, so no
// clearing pass follows reset. default_window may be written only while no
// request is in flight.
// ----------------------------------------------------------------------------
module multi_slot_heartbeat_watchdog import mshw_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] slot_key, [63:32] window_ticks
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [1:0] status_code, [3:2] slot_state,
                                  // [35:4] ticks_left, [67:36] freezes_seen,
                                  // [68] timeout_fired, [71:69] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  req_t q_in;
  req_t q_out;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  res_t res;
  logic bk_fire;

  // Front end
  mshw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Request queue
  mshw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Table engine
  mshw_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_res   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .bk_fire   (bk_fire)
  );

  assign out_tdata = {3'b000, res};

  // A reply appears only after the engine completed a request
  a_reply_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(bk_fire))
    else $error("reply raised without an engine completion");

  // The queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request queue overflow");

  // The engine never pops from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request queue underflow");

  // A timeout is reported only with an ok status
  a_timeout_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[68]) |-> (out_tdata[1:0] == RC_OK))
    else $error("timeout flag with non-ok status");

endmodule

// ===== test/multi_slot_heartbeat_watchdog_test.sv =====
// ----------------------------------------------------------------------------
// multi_slot_heartbeat_watchdog_test
// Self-checking bench for the keyed heartbeat watchdog table. A shadow copy
// of the entry table predicts one reply for every accepted request beat, and
// the monitor compares each reply field by field. A directed opening covers
// each request kind and its corner cases. It is followed by randomized
// phases of register / heartbeat / freeze / resume / unregister sequences
// on a small key pool, with random noise mixed in. Each phase uses its own
// default_window setting; the first and last run with no gaps or stalls.
// ----------------------------------------------------------------------------
module multi_slot_heartbeat_watchdog_test;
  import mshw_pkg::*;

  localparam int SLOTS      = 16;
  localparam int KEY_POOL   = 20;       // more keys than slots, so the table fills
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 8;

  // Request codes the block does not define
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] win;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // [31:0] slot_key, [63:32] window_ticks
  logic [2:0]  in_tuser = '0;    // [2:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // [1:0] code, [3:2] state, [35:4] ticks,
                                 // [67:36] freezes, [68] fired
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  multi_slot_heartbeat_watchdog #(.SLOTS(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Shadow entry table and default window
  slot_st_t    tbl_st      [SLOTS];
  logic [31:0] tbl_key     [SLOTS];
  logic [31:0] tbl_window  [SLOTS];
  logic [31:0] tbl_ticks   [SLOTS];
  logic [31:0] tbl_freezes [SLOTS];
  logic [31:0] dflt_window = DEFAULT_WINDOW_RST;

  request_t    requests_pending[$];
  res_t        replies_due[$];
  logic [31:0] key_pool[KEY_POOL];

  request_t    next_beat;
  res_t        predicted;
  res_t        observed;
  res_t        oldest;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          beats_sent = 0;
  int          replies_checked = 0;
  int          timeouts_fired = 0;
  int          full_replies = 0;
  int          cfg_writes = 0;
  int          cycles = 0;

  // Apply one request to the shadow table and return the reply it earns
  function automatic res_t serve_request(logic [2:0] kind, logic [31:0] key,
                                         logic [31:0] win);
    res_t r;
    int   hit;
    r   = '0;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && tbl_st[i] != ST_FREE && tbl_key[i] == key) hit = i;
    case (kind)
      REQ_REGISTER: begin
        if (win == 0) win = dflt_window;
        if (hit < 0)
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_st[i] == ST_FREE) hit = i;
        if (hit < 0) begin
          r.code = RC_FULL;
          full_replies++;
        end else begin
          tbl_key[hit]     = key;
          tbl_st[hit]      = ST_ACTIVE;
          tbl_window[hit]  = win;
          tbl_ticks[hit]   = win;
          tbl_freezes[hit] = '0;
        end
      end
      REQ_HEARTBEAT: begin
        if (hit < 0) r.code = RC_NOENT;
        else if (tbl_st[hit] == ST_ACTIVE) begin
          if (tbl_ticks[hit] == 0) begin
            tbl_st[hit] = ST_TIMEDOUT;
            r.fired     = 1'b1;
            timeouts_fired++;
          end else begin
            tbl_ticks[hit] = tbl_ticks[hit] - 1;
          end
        end
      end
      REQ_STATUS: begin
        if (hit < 0) r.code = RC_NOENT;
        else begin
          r.state   = tbl_st[hit];
          r.ticks   = tbl_ticks[hit];
          r.freezes = tbl_freezes[hit];
        end
      end
      REQ_UNREGISTER: begin
        if (hit < 0) r.code = RC_NOENT;
        else tbl_st[hit] = ST_FREE;
      end
      REQ_FREEZE: begin
        if (hit < 0) r.code = RC_NOENT;
        else begin
          tbl_st[hit]      = ST_FROZEN;
          tbl_freezes[hit] = tbl_freezes[hit] + 1;
        end
      end
      REQ_RESUME: begin
        if (hit < 0) r.code = RC_NOENT;
        else begin
          tbl_st[hit]    = ST_ACTIVE;
          tbl_ticks[hit] = tbl_window[hit];
        end
      end
      default: r.code = RC_NOENT;
    endcase
    return r;
  endfunction

  task automatic queue_request(logic [2:0] kind, logic [31:0] key, logic [31:0] win);
    request_t q;
    q.kind = kind;
    q.key  = key;
    q.win  = win;
    requests_pending.push_back(q);
  endtask

  // Mostly short windows so timeouts happen; some default, some full range
  function automatic logic [31:0] pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 8) return $urandom_range(1, 4);
    if (r == 8) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  // Randomized traffic: well-formed entry lifecycles, table fills,
  // unregister sweeps and raw noise
  task automatic plan_traffic(int count);
    int          n;
    int          pick;
    int          beats;
    int          off;
    logic [31:0] key;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      key  = key_pool[$urandom_range(0, KEY_POOL - 1)];
      if (pick < 55) begin
        queue_request(REQ_REGISTER, key, pick_window());
        beats = $urandom_range(0, 6);
        n += 1 + beats;
        repeat (beats) begin
          if ($urandom_range(0, 3) == 0) queue_request(REQ_STATUS, key, $urandom);
          else queue_request(REQ_HEARTBEAT, key, $urandom);
        end
        if ($urandom_range(0, 9) < 4) begin
          queue_request(REQ_FREEZE, key, $urandom);
          queue_request(REQ_HEARTBEAT, key, $urandom);
          queue_request(REQ_STATUS, key, $urandom);
          queue_request(REQ_RESUME, key, $urandom);
          n += 4;
        end else if ($urandom_range(0, 9) == 0) begin
          queue_request(REQ_RESUME, key, $urandom);
          n += 1;
        end
        queue_request(REQ_STATUS, key, $urandom);
        n += 1;
        if ($urandom_range(0, 1) == 0) begin
          queue_request(REQ_UNREGISTER, key, $urandom);
          n += 1;
        end
      end else if (pick < 70) begin
        off   = $urandom_range(0, KEY_POOL - 1);
        beats = $urandom_range(4, KEY_POOL);
        for (int j = 0; j < beats; j++)
          queue_request(REQ_REGISTER, key_pool[(off + j) % KEY_POOL], pick_window());
        n += beats;
      end else if (pick < 80) begin
        beats = $urandom_range(2, 10);
        repeat (beats)
          queue_request(REQ_UNREGISTER, key_pool[$urandom_range(0, KEY_POOL - 1)],
                        $urandom);
        n += beats;
      end else begin
        if ($urandom_range(0, 1) == 0) key = $urandom;
        queue_request(3'($urandom_range(0, 7)), key, $urandom);
        n += 1;
      end
    end
  endtask

  // Wait until no beat is queued, in flight or owed a reply; checked on the
  // falling edge so the driver's pop and valid update are both settled
  task automatic drain();
    while (requests_pending.size() != 0 || in_tvalid || replies_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_default_window(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    dflt_window = value;
    cfg_writes++;
  endtask

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Request source: holds a beat until taken, then maybe idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = serve_request(in_tuser, in_tdata[31:0], in_tdata[63:32]);
        replies_due.push_back(predicted);
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = requests_pending.pop_front();
          in_tuser  <= next_beat.kind;
          in_tdata  <= {next_beat.win, next_beat.key};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply sink and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        observed = out_tdata[68:0];
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: reply with nothing outstanding: %h", out_tdata);
        end else begin
          oldest = replies_due.pop_front();
          replies_checked++;
          if (observed.code !== oldest.code || observed.state !== oldest.state ||
              observed.ticks !== oldest.ticks || observed.freezes !== oldest.freezes ||
              observed.fired !== oldest.fired) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: reply %0d exp code=%0d st=%0d ticks=%0d frz=%0d fired=%0d, got code=%0d st=%0d ticks=%0d frz=%0d fired=%0d",
                       replies_checked, oldest.code, oldest.state, oldest.ticks,
                       oldest.freezes, oldest.fired, observed.code, observed.state,
                       observed.ticks, observed.freezes, observed.fired);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on the bench itself
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("ERROR: run stalled, %0d replies still outstanding", replies_due.size());
      $display("multi_slot_heartbeat_watchdog test failed");
      $finish;
    end
  end

  // Stimulus sequencing
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_st[i]      = ST_FREE;
      tbl_key[i]     = '0;
      tbl_window[i]  = '0;
      tbl_ticks[i]   = '0;
      tbl_freezes[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, default window at its reset value
    queue_request(REQ_STATUS,     32'h0,         32'h0);   // unknown key
    queue_request(REQ_HEARTBEAT,  32'h0,         32'h0);
    queue_request(REQ_REGISTER,   32'h0,         32'h0);   // default window
    queue_request(REQ_STATUS,     32'h0,         32'h0);
    queue_request(REQ_REGISTER,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(REQ_REGISTER,   32'h5,         32'h1);
    queue_request(REQ_HEARTBEAT,  32'h5,         32'h0);
    queue_request(REQ_HEARTBEAT,  32'h5,         32'h0);   // fires
    queue_request(REQ_HEARTBEAT,  32'h5,         32'h0);   // absorbed, timed out
    queue_request(REQ_STATUS,     32'h5,         32'h0);
    queue_request(REQ_FREEZE,     32'h5,         32'h0);   // freeze a timed-out entry
    queue_request(REQ_HEARTBEAT,  32'h5,         32'h0);   // absorbed, frozen
    queue_request(REQ_FREEZE,     32'h5,         32'h0);
    queue_request(REQ_STATUS,     32'h5,         32'h0);
    queue_request(REQ_RESUME,     32'h5,         32'hFFFF_FFFF);
    queue_request(REQ_STATUS,     32'h5,         32'h0);
    queue_request(REQ_REGISTER,   32'h5,         32'h2);   // re-arm clears freezes
    queue_request(REQ_STATUS,     32'h5,         32'h0);
    queue_request(REQ_UNREGISTER, 32'h5,         32'h0);
    queue_request(REQ_UNREGISTER, 32'h5,         32'h0);
    queue_request(REQ_FREEZE,     32'h5,         32'h0);
    queue_request(REQ_RESUME,     32'h5,         32'h0);
    queue_request(REQ_STATUS,     32'hFFFF_FFFF, 32'h0);
    queue_request(REQ_SPARE6,     32'h0,         32'hFFFF_FFFF);
    queue_request(REQ_SPARE7,     32'hFFFF_FFFF, 32'h0);
    drain();

    // Random phases: smallest nonzero window, no backpressure
    write_default_window(32'h1);
    plan_traffic(300);
    drain();

    // Largest window, sparse source
    write_default_window(32'hFFFF_FFFF);
    send_idle_pct <= 83;
    plan_traffic(300);
    drain();

    // Zero default, so default-armed entries time out on the next heartbeat
    write_default_window(32'h0);
    send_idle_pct  <= 0;
    recv_stall_pct <= 83;
    plan_traffic(300);
    drain();

    // Short default, light gaps on both sides
    write_default_window(32'h3);
    send_idle_pct  <= 13;
    recv_stall_pct <= 13;
    plan_traffic(300);
    drain();

    // Random default, back to full rate
    write_default_window($urandom_range(2, 40));
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    plan_traffic(300);
    drain();

    $display("Ran %0d requests over %0d default_window settings; %0d replies checked",
             beats_sent, cfg_writes + 1, replies_checked);
    $display("Saw %0d heartbeat timeouts and %0d table-full replies, %0d mismatches",
             timeouts_fired, full_replies, errors);
    if (errors == 0)
      $display("multi_slot_heartbeat_watchdog test passed");
    else
      $display("multi_slot_heartbeat_watchdog test failed");
    $finish;
  end

endmodule
